### rtl/tlv_pkg.sv
package tlv_pkg;

	// Frame-size cap and the widths that follow from it.
	localparam int MAX_FRAME_BYTES = 4096;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

	// Routing register file.
	localparam int ROUTE_COUNT = 8;
	localparam int ROUTE_W     = 15;
	localparam int CFG_IDX_W   = 4;
	localparam int ROUTE_EN_BIT = 14;
	localparam int TAG_LSB     = 6;
	localparam int CHAN_W      = 6;

	// Value gathering.
	localparam int VALUE_BYTES_KEPT = 8;
	localparam int VALUE_W          = 64;
	localparam int GATH_W           = 4;

	// Queue between the parser and the router.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ROUTE_W-1:0] ROUTE_RESET [ROUTE_COUNT] = '{
		15'd16448, 15'd16513, 15'd16578, 15'd16643, 15'd16708, 15'd0, 15'd0, 15'd0
	};

	// Event passed from the parser to the router.
	typedef struct packed {
		logic               complete;
		logic               last;
		logic [7:0]         tag;
		logic [VALUE_W-1:0] value;
	} tlv_event_t;

endpackage

### rtl/tlv_entry_extractor_top.sv
// TLV entry extractor.
// Input channel (in_valid/in_ready): one frame byte per transaction in data_byte,
// with frame_last high on the final byte of the frame. Each entry is a tag byte,
// a length byte and that many value bytes; the first eight value bytes form a
// big-endian 64-bit value.
// Output channel (out_valid/out_ready): one transaction per routed entry and one
// on every frame end (frame_done set); both may fall on the same transaction.
// Configuration channel (cfg_valid/cfg_ready): writes routing register cfg_index
// (0 to 7) with cfg_data; cfg_ready is always high. Write only while idle.
// Throughput is one byte per cycle while the queue has room. For each byte that
// causes a result, the parser pushes an event into a two-entry queue, and the
// router compares the tag against all eight routes and loads the output register.
// When the receiver stalls, the output register holds, the queue fills, and
// in_ready drops once both queue entries are occupied.
// Reset clears the parser, empties the queue and output, and loads the default
// routes (tags 1 to 5 to channels 0 to 4).
module tlv_entry_extractor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           frame_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tlv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlv_pkg::ROUTE_W-1:0]    cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           entry_valid,
	output logic [tlv_pkg::CHAN_W-1:0]     channel,
	output logic [tlv_pkg::VALUE_W-1:0]    entry_value,
	output logic                           frame_done
);
	import tlv_pkg::*;

	logic       q_ready;
	logic       q_push;
	tlv_event_t q_event;
	logic       q_pop;
	logic       q_head_valid;
	tlv_event_t q_head_event;

	// Byte parser.
	tlv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_last(frame_last),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_event   (q_event)
	);

	// Event queue.
	tlv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_ready(q_ready),
		.push_event(q_event),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_event(q_head_event)
	);

	// Router and output register.
	tlv_route u_route (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (q_head_valid),
		.head_event (q_head_event),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.entry_valid(entry_valid),
		.channel    (channel),
		.entry_value(entry_value),
		.frame_done (frame_done)
	);

endmodule

### rtl/tlv_front.sv
module tlv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 frame_last,
	input  logic                 q_ready,
	output logic                 q_push,
	output tlv_pkg::tlv_event_t  q_event
);
	import tlv_pkg::*;

	typedef enum logic [1:0] {
		PH_TAG = 2'd0,
		PH_LEN = 2'd1,
		PH_VAL = 2'd2
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [7:0]         tag_q, tag_n;
	logic [7:0]         left_q, left_n;
	logic [GATH_W-1:0]  gath_q, gath_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [VALUE_W-1:0] ev_value;
	logic               complete;
	logic               accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	// Next parse state for the byte on the input.
	always_comb begin
		phase_n  = phase_q;
		tag_n    = tag_q;
		left_n   = left_q;
		gath_n   = gath_q;
		acc_n    = acc_q;
		pos_n    = pos_q;
		complete = 1'b0;
		if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
			pos_n = pos_q + POS_W'(1);
			case (phase_q)
				PH_LEN: begin
					left_n = data_byte;
					gath_n = '0;
					acc_n  = '0;
					if (data_byte == 8'd0) begin
						complete = 1'b1;
					end else begin
						phase_n = PH_VAL;
					end
				end
				PH_VAL: begin
					if (gath_q < GATH_W'(VALUE_BYTES_KEPT)) begin
						acc_n  = {acc_q[VALUE_W-9:0], data_byte};
						gath_n = gath_q + GATH_W'(1);
					end
					left_n = left_q - 8'd1;
					if (left_n == 8'd0) begin
						complete = 1'b1;
					end
				end
				default: begin
					tag_n   = data_byte;
					phase_n = PH_LEN;
				end
			endcase
			if (complete) begin
				phase_n = PH_TAG;
			end
		end
		// The entry value is taken before a frame end clears the accumulator.
		ev_value = acc_n;
		// The last byte of a frame restarts the parser.
		if (frame_last) begin
			phase_n = PH_TAG;
			tag_n   = '0;
			left_n  = '0;
			gath_n  = '0;
			acc_n   = '0;
			pos_n   = '0;
		end
	end

	// An event is queued for every completed entry and every frame end.
	assign q_push           = accept && (complete || frame_last);
	assign q_event.complete = complete;
	assign q_event.last     = frame_last;
	assign q_event.tag      = tag_q;
	assign q_event.value    = ev_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= '0;
			left_q  <= '0;
			gath_q  <= '0;
			acc_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			left_q  <= left_n;
			gath_q  <= gath_n;
			acc_q   <= acc_n;
			pos_q   <= pos_n;
		end
	end

endmodule

### rtl/tlv_queue.sv
module tlv_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 push_ready,
	input  tlv_pkg::tlv_event_t  push_event,
	input  logic                 pop,
	output logic                 head_valid,
	output tlv_pkg::tlv_event_t  head_event
);
	import tlv_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tlv_event_t       slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_event = slots_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Event storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_event;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/tlv_route.sv
module tlv_route (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tlv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlv_pkg::ROUTE_W-1:0]    cfg_data,
	input  logic                           head_valid,
	input  tlv_pkg::tlv_event_t            head_event,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           entry_valid,
	output logic [tlv_pkg::CHAN_W-1:0]     channel,
	output logic [tlv_pkg::VALUE_W-1:0]    entry_value,
	output logic                           frame_done
);
	import tlv_pkg::*;

	logic [ROUTE_W-1:0] route_q [ROUTE_COUNT];
	logic               hit;
	logic [CHAN_W-1:0]  hit_chan;
	logic               emit;
	logic               out_valid_q;
	logic               entry_valid_q;
	logic [CHAN_W-1:0]  channel_q;
	logic [VALUE_W-1:0] value_q;
	logic               done_q;

	assign cfg_ready = 1'b1;

	// Routing registers; writes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROUTE_COUNT; k++) begin
				route_q[k] <= ROUTE_RESET[k];
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(ROUTE_COUNT))) begin
			route_q[cfg_index[$clog2(ROUTE_COUNT)-1:0]] <= cfg_data;
		end
	end

	// Parallel tag compare; the lowest-numbered enabled match wins.
	always_comb begin
		hit      = 1'b0;
		hit_chan = '0;
		for (int k = ROUTE_COUNT - 1; k >= 0; k--) begin
			if (route_q[k][ROUTE_EN_BIT] && (route_q[k][TAG_LSB +: 8] == head_event.tag)) begin
				hit      = head_event.complete;
				hit_chan = route_q[k][CHAN_W-1:0];
			end
		end
	end

	// Take the queue head when the output register is free or draining.
	assign pop  = head_valid && (!out_valid_q || out_ready);
	assign emit = hit || head_event.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			entry_valid_q <= hit;
			channel_q     <= hit ? hit_chan : '0;
			value_q       <= hit ? head_event.value : '0;
			done_q        <= head_event.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_valid = entry_valid_q;
	assign channel     = channel_q;
	assign entry_value = value_q;
	assign frame_done  = done_q;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tlv_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 6;
	// Covers the path from byte to result through the event queue and the output register.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTED  = 10;

	typedef enum logic [1:0] {
		AWAIT_TAG   = 2'd0,
		AWAIT_LEN   = 2'd1,
		AWAIT_VALUE = 2'd2
	} parse_phase_e;

	typedef struct packed {
		logic               entry_valid;
		logic [CHAN_W-1:0]  channel;
		logic [VALUE_W-1:0] value;
		logic               frame_done;
	} tlv_result_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
		int         gap;
	} tx_byte_t;

	// Tracks the parser and the routing registers, and checks each result.
	class tlv_scoreboard;
		logic [ROUTE_W-1:0] routes [ROUTE_COUNT];
		parse_phase_e       phase;
		logic [7:0]         held_tag;
		logic [7:0]         bytes_left;
		logic [GATH_W-1:0]  gathered;
		logic [VALUE_W-1:0] acc;
		logic [POS_W-1:0]   frame_pos;
		tlv_result_t        expected_results [$];
		int                 mismatches;
		int                 results_checked;
		int                 routed_entries;
		int                 frames;

		function new();
			foreach (routes[k])
				routes[k] = ROUTE_RESET[k];
			clear_parse();
			mismatches = 0;
			results_checked = 0;
			routed_entries = 0;
			frames = 0;
		endfunction

		function void clear_parse();
			phase = AWAIT_TAG;
			held_tag = '0;
			bytes_left = '0;
			gathered = '0;
			acc = '0;
			frame_pos = '0;
		endfunction

		function void write_route(int idx, logic [ROUTE_W-1:0] data);
			if (idx < ROUTE_COUNT)
				routes[idx] = data;
		endfunction

		// Advance the parser by one accepted byte and queue any result it causes.
		function void note_byte(logic [7:0] b, logic last);
			logic               complete;
			logic               hit;
			logic [CHAN_W-1:0]  chan;
			logic [VALUE_W-1:0] val;
			tlv_result_t        r;
			complete = 1'b0;
			hit = 1'b0;
			chan = '0;
			val = '0;
			if (frame_pos < MAX_FRAME_BYTES) begin
				frame_pos++;
				case (phase)
					AWAIT_LEN: begin
						bytes_left = b;
						gathered = '0;
						acc = '0;
						if (b == 8'd0)
							complete = 1'b1;
						else
							phase = AWAIT_VALUE;
					end
					AWAIT_VALUE: begin
						if (gathered < VALUE_BYTES_KEPT) begin
							acc = {acc[VALUE_W-9:0], b};
							gathered++;
						end
						bytes_left--;
						if (bytes_left == 8'd0)
							complete = 1'b1;
					end
					default: begin
						held_tag = b;
						phase = AWAIT_LEN;
					end
				endcase
				// The lowest-numbered enabled route with a matching tag wins.
				if (complete) begin
					phase = AWAIT_TAG;
					for (int k = 0; k < ROUTE_COUNT; k++) begin
						if (!hit && routes[k][ROUTE_EN_BIT] &&
						    routes[k][TAG_LSB +: 8] == held_tag) begin
							hit = 1'b1;
							chan = routes[k][CHAN_W-1:0];
						end
					end
					if (hit)
						val = acc;
				end
			end
			if (last) begin
				clear_parse();
				frames++;
			end
			if (hit || last) begin
				r.entry_valid = hit;
				r.channel = chan;
				r.value = val;
				r.frame_done = last;
				expected_results.push_back(r);
				if (hit)
					routed_entries++;
			end
		endfunction

		function void report(string what, tlv_result_t e, tlv_result_t a);
			mismatches++;
			if (mismatches <= MAX_REPORTED)
				$display("[%0t] %s: exp valid=%0b chan=%0d value=%h done=%0b, got valid=%0b chan=%0d value=%h done=%0b",
				         $realtime, what, e.entry_valid, e.channel, e.value, e.frame_done,
				         a.entry_valid, a.channel, a.value, a.frame_done);
		endfunction

		function void check_result(tlv_result_t act);
			tlv_result_t exp;
			results_checked++;
			if (expected_results.size() == 0) begin
				exp = '0;
				report("unexpected result", exp, act);
			end else begin
				exp = expected_results.pop_front();
				if (act.entry_valid !== exp.entry_valid || act.channel !== exp.channel ||
				    act.value !== exp.value || act.frame_done !== exp.frame_done)
					report("result mismatch", exp, act);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           data_byte;
	logic                 frame_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ROUTE_W-1:0]   cfg_data;
	logic                 out_valid;
	logic                 out_ready;
	logic                 entry_valid;
	logic [CHAN_W-1:0]    channel;
	logic [VALUE_W-1:0]   entry_value;
	logic                 frame_done;

	tlv_scoreboard sb = new();
	tx_byte_t      tx_q [$];
	bit            steady;
	int            hold_req;
	int            stall_left;
	int            bytes_sent;
	int            cfg_writes;

	tlv_entry_extractor_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_last  (frame_last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_valid (entry_valid),
		.channel     (channel),
		.entry_value (entry_value),
		.frame_done  (frame_done)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Observe every transaction on the rising edge.
	always @(posedge clk) begin
		tlv_result_t act;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				act.entry_valid = entry_valid;
				act.channel = channel;
				act.value = entry_value;
				act.frame_done = frame_done;
				sb.check_result(act);
			end
			if (in_valid && in_ready)
				sb.note_byte(data_byte, frame_last);
			if (cfg_valid && cfg_ready)
				sb.write_route(int'(cfg_index), cfg_data);
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (hold_req > 0) begin
				out_ready <= 1'b0;
				stall_left = hold_req - 1;
				hold_req = 0;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = gap_len() - 1;
			end
		end
	end

	task automatic add_byte(logic [7:0] b, logic last);
		tx_byte_t t;
		t.b = b;
		t.last = last;
		t.gap = (steady || $urandom_range(0, 2) != 0) ? 0 : gap_len();
		tx_q.push_back(t);
	endtask

	// Send every queued byte, then drop valid.
	task automatic drive_stream();
		tx_byte_t t;
		while (tx_q.size() > 0) begin
			t = tx_q.pop_front();
			if (t.gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (t.gap - 1) @(negedge clk);
			end
			@(negedge clk);
			in_valid <= 1'b1;
			data_byte <= t.b;
			frame_last <= t.last;
			bytes_sent++;
			do @(posedge clk); while (!in_ready);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait for every expected result, then let the pipeline empty.
	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes stay one transaction per cycle.
	task automatic write_route(int idx, logic [ROUTE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	task automatic cfg_release();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ROUTE_W-1:0] route_word(logic en, logic [7:0] tag,
	                                                  logic [CHAN_W-1:0] chan);
		return {en, tag, chan};
	endfunction

	// Mostly a tag that some enabled route knows, otherwise any byte.
	function automatic logic [7:0] pick_tag();
		logic [7:0] known [$];
		foreach (sb.routes[k])
			if (sb.routes[k][ROUTE_EN_BIT])
				known.push_back(sb.routes[k][TAG_LSB +: 8]);
		if (known.size() > 0 && $urandom_range(0, 9) < 7)
			return known[$urandom_range(0, known.size() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		if (r < 80)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 20);
		return $urandom_range(21, 64);
	endfunction

	// One frame: well-formed entries, sometimes ended early, sometimes plain noise.
	task automatic add_random_frame();
		logic [7:0] fb [$];
		int         n;
		int         len;
		int         ending;
		int         cut;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 20);
			repeat (n) fb.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				len = pick_len();
				fb.push_back(pick_tag());
				fb.push_back(8'(len));
				repeat (len) fb.push_back(8'($urandom_range(0, 255)));
			end
			ending = $urandom_range(0, 9);
			if (ending == 7) begin
				cut = $urandom_range(1, fb.size() - 1);
				while (fb.size() > cut)
					void'(fb.pop_back());
			end else if (ending == 8) begin
				fb.push_back(pick_tag());
			end else if (ending == 9) begin
				fb.push_back(pick_tag());
				fb.push_back(8'($urandom_range(1, 8)));
			end
		end
		foreach (fb[i])
			add_byte(fb[i], i == fb.size() - 1);
	endtask

	// Random frames with idling, then a stretch with none.
	task automatic random_phase(int nbytes);
		steady = 1'b0;
		while (tx_q.size() < nbytes * 2 / 3)
			add_random_frame();
		drive_stream();
		steady = 1'b1;
		while (tx_q.size() < nbytes / 3)
			add_random_frame();
		drive_stream();
		steady = 1'b0;
	endtask

	initial begin
		#50_000_000;
		$display("** tlv_entry_extractor_top: FAILED **");
		$finish;
	end

	initial begin
		// Zero length, long value, unrouted tag, entry ending on the last byte,
		// then a lone trailing tag byte.
		logic [7:0] directed [25] = '{
			8'h01, 8'h00,
			8'h02, 8'h03, 8'hAA, 8'hBB, 8'hCC,
			8'hFF, 8'h00,
			8'h03, 8'h0A, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
			8'h09, 8'h0A,
			8'h05, 8'h01, 8'hFF,
			8'h04
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		frame_last = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		hold_req = 0;
		bytes_sent = 0;
		cfg_writes = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames under the default routes.
		foreach (directed[i])
			add_byte(directed[i], i == 23 || i == 24);
		drive_stream();
		drain();

		// A frame longer than the cap: one entry straddles it, later bytes are ignored.
		steady = 1'b1;
		repeat (15) begin
			add_byte(8'h01, 1'b0);
			add_byte(8'hFF, 1'b0);
			repeat (255) add_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		add_byte(8'h02, 1'b0);
		add_byte(8'hFF, 1'b0);
		while (tx_q.size() < MAX_FRAME_BYTES + 3)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		add_byte(8'($urandom_range(0, 255)), 1'b1);
		add_byte(8'h01, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h77, 1'b1);
		drive_stream();
		steady = 1'b0;
		drain();

		// Duplicate tags, a disabled match ahead of an enabled one, field extremes.
		write_route(0, '0);
		write_route(1, route_word(1'b1, 8'h10, 6'd5));
		write_route(2, route_word(1'b1, 8'h10, 6'd9));
		write_route(3, route_word(1'b0, 8'hAA, 6'd33));
		write_route(4, route_word(1'b1, 8'hAA, 6'd21));
		write_route(5, route_word(1'b1, 8'h00, 6'd0));
		write_route(6, route_word(1'b1, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63))));
		write_route(7, 15'h7FFF);
		write_route(15, 15'($urandom_range(0, 32767)));
		cfg_release();

		// Receiver holds off while the sender keeps offering bytes.
		steady = 1'b1;
		hold_req = 60;
		repeat (20) begin
			add_byte(8'h10, 1'b0);
			add_byte(8'h00, 1'b0);
		end
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		drive_stream();
		steady = 1'b0;
		drain();

		random_phase(170);
		drain();

		// No route enabled: only frame ends report.
		for (int k = 0; k < ROUTE_COUNT; k++)
			write_route(k, '0);
		cfg_release();
		random_phase(80);
		drain();

		// Random routing.
		for (int k = 0; k < ROUTE_COUNT; k++)
			write_route(k, 15'($urandom_range(0, 32767)));
		cfg_release();
		random_phase(190);
		drain();

		$display("Sent %0d bytes in %0d frames with %0d register writes.",
		         bytes_sent, sb.frames, cfg_writes);
		$display("Checked %0d results, %0d of them routed entries; %0d mismatches.",
		         sb.results_checked, sb.routed_entries, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** tlv_entry_extractor_top: PASSED **");
		end else begin
			if (sb.pending() != 0)
				$display("%0d expected results never arrived.", sb.pending());
			$display("** tlv_entry_extractor_top: FAILED **");
		end
		$finish;
	end

endmodule
